>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and reset
`define FTBA_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// uses the module's clk and rst_n
`define FTBA_ASSERT(label, prop, msg) \
    `FTBA_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

>>> src/ftba_pkg.sv
// ----------------------------------------------------------------------------
// ftba_pkg
// Types, codes and constants of the file table block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ftba_pkg;

    localparam int FILE_SLOTS_DEF   = 16;
    localparam int NUM_BLOCKS_DEF   = 1024;
    localparam int BLOCK_BYTES_LOG2 = 10;
    localparam int BLOCK_BYTES      = 1 << BLOCK_BYTES_LOG2;
    localparam int NAME_BYTES       = 8;
    localparam int READ_RUN_MAX     = 64;

    localparam int POS_W  = 22;
    localparam int NEED_W = POS_W - BLOCK_BYTES_LOG2;
    localparam int RUN_W  = 7;

    localparam logic [63:0] KEY_MASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    typedef enum logic [1:0] {
        K_CREATE = 2'd0,
        K_DELETE = 2'd1,
        K_WRITE  = 2'd2,
        K_READ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EXISTS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOSPACE  = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_TOOLONG  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CR_RD,
        ST_CR_CHK,
        ST_CR_DONE,
        ST_DL_RD,
        ST_DL_FREE,
        ST_DL_DONE,
        ST_WR_MAP,
        ST_WR_STORE,
        ST_RD_MAP,
        ST_RD_ADDR,
        ST_RD_EMIT
    } state_t;

    typedef struct packed {
        kind_t        kind;
        logic [63:0]  name_key;
        logic [20:0]  amount;
        logic [20:0]  offset;
        logic [19:0]  byte_pos;
        logic [7:0]   data_byte;
    } req_item_t;

    typedef struct packed {
        status_t      status;
        logic [7:0]   read_byte;
        logic [10:0]  blocks_given;
        logic         last;
    } rsp_item_t;

    // classified item as queued between front and back
    typedef struct packed {
        kind_t               kind;
        logic [63:0]         key;
        logic [20:0]         amount;
        logic [20:0]         offset;
        logic [7:0]          data_byte;
        logic [POS_W-1:0]    wpos;
        logic [POS_W-1:0]    end_pos;
        logic [NEED_W-1:0]   need;
        logic                bad_pos;
        logic                too_long;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_link_t;

endpackage

`default_nettype wire

>>> src/ftba_chan_if.sv
// ----------------------------------------------------------------------------
// ftba channel interfaces
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftba_req_if import ftba_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface ftba_rsp_if import ftba_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> src/ftba_front.sv
// ----------------------------------------------------------------------------
// ftba_front
// Accepts request beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ftba_front import ftba_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ftba_req_if.sink   req,
    output q_link_t    q_link,
    input  wire logic  q_ready
);

    q_item_t     fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    q_item_t     cls;
    logic        push;
    logic        pop;

    always_comb
    begin
        cls.kind      = req.item.kind;
        cls.key       = req.item.name_key & KEY_MASK;
        cls.amount    = req.item.amount;
        cls.offset    = req.item.offset;
        cls.data_byte = req.item.data_byte;
        cls.wpos      = POS_W'(req.item.offset) + POS_W'(req.item.byte_pos);
        cls.end_pos   = POS_W'(req.item.offset) + POS_W'(req.item.amount);
        cls.need      = NEED_W'((POS_W'(req.item.amount) + POS_W'(BLOCK_BYTES - 1))
                        >> BLOCK_BYTES_LOG2);
        cls.bad_pos   = 21'(req.item.byte_pos) >= req.item.amount;
        cls.too_long  = req.item.amount > 21'(READ_RUN_MAX);
    end

    assign req.ready    = (cnt_reg != 2'd2);
    assign push         = req.valid && req.ready;
    assign pop          = q_ready && (cnt_reg != 2'd0);
    assign q_link.valid = (cnt_reg != 2'd0);
    assign q_link.item  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

>>> src/ftba_back.sv
// ----------------------------------------------------------------------------
// ftba_back
// Slot table, block bitmap, block lists and byte store; executes items.
// ----------------------------------------------------------------------------
`default_nettype none

module ftba_back import ftba_pkg::*; #(
    parameter int FILE_SLOTS = FILE_SLOTS_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_link_t q_link,
    output logic         q_ready,
    ftba_rsp_if.source   rsp
);

    localparam int SW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LD  = FILE_SLOTS * NUM_BLOCKS;
    localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
    localparam int AW  = BW + BLOCK_BYTES_LOG2;
    localparam int SD  = NUM_BLOCKS * BLOCK_BYTES;
    localparam int FW  = $clog2(NUM_BLOCKS + 1);
    localparam int CW  = (FW > NEED_W) ? FW : NEED_W;

    // slot table
    logic [FILE_SLOTS-1:0] slot_used_reg;
    logic [63:0]           slot_key_reg   [FILE_SLOTS];
    logic [20:0]           slot_size_reg  [FILE_SLOTS];
    logic [NEED_W-1:0]     slot_count_reg [FILE_SLOTS];

    // memories
    logic                  taken_mem [NUM_BLOCKS];
    logic [BW-1:0]         list_mem  [LD];
    logic [7:0]            store_mem [SD];
    logic                  taken_q;
    logic [BW-1:0]         list_q;
    logic [7:0]            store_q;

    state_t                state_reg, state_next;
    q_item_t               item_reg, item_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [BW-1:0]         idx_reg, idx_next;
    logic [NEED_W-1:0]     cnt_reg, cnt_next;
    logic [FW-1:0]         free_reg, free_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic                  out_valid_reg;
    rsp_item_t             out_reg, out_next;
    logic                  out_load;

    logic                  can_emit;
    logic [FILE_SLOTS-1:0] hit_vec;
    logic                  hit;
    logic [SW-1:0]         hit_idx;
    logic                  free_any;
    logic [SW-1:0]         free_idx;
    logic [SW-1:0]         sel_slot;
    logic [20:0]           sel_size;
    logic [NEED_W-1:0]     sel_count;
    logic [POS_W-1:0]      rpos;

    logic                  taken_re, taken_we, taken_wd;
    logic [BW-1:0]         taken_a;
    logic                  list_re, list_we;
    logic [LAW-1:0]        list_ra, list_wa;
    logic [BW-1:0]         list_wd;
    logic                  store_re, store_we;
    logic [AW-1:0]         store_a;
    logic                  slot_set, slot_clr;

    function automatic logic [LAW-1:0] list_addr(input logic [SW-1:0] s,
                                                 input logic [NEED_W-1:0] lblk);
        return LAW'(LAW'(s) * LAW'(NUM_BLOCKS)) + LAW'(lblk);
    endfunction

    assign can_emit  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int s = 0; s < FILE_SLOTS; s++)
            hit_vec[s] = slot_used_reg[s] && (slot_key_reg[s] == q_link.item.key);
        for (int s = FILE_SLOTS - 1; s >= 0; s--)
        begin
            if (hit_vec[s])
                hit_idx = SW'(s);
            if (!slot_used_reg[s])
                free_idx = SW'(s);
        end
        hit      = |hit_vec;
        free_any = !(&slot_used_reg);
    end

    assign sel_slot  = (state_reg == ST_IDLE) ? hit_idx : slot_reg;
    assign sel_size  = slot_size_reg[sel_slot];
    assign sel_count = slot_count_reg[sel_slot];
    assign rpos      = POS_W'(item_reg.offset) + POS_W'(run_reg);

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        run_next   = run_reg;
        out_load   = 1'b0;
        out_next   = '{status: STAT_OK, read_byte: 8'd0, blocks_given: 11'd0, last: 1'b1};
        q_ready    = 1'b0;
        taken_re   = 1'b0;
        taken_we   = 1'b0;
        taken_wd   = 1'b0;
        taken_a    = idx_reg;
        list_re    = 1'b0;
        list_we    = 1'b0;
        list_ra    = list_addr(slot_reg, cnt_reg);
        list_wa    = list_addr(slot_reg, cnt_reg);
        list_wd    = idx_reg;
        store_re   = 1'b0;
        store_we   = 1'b0;
        store_a    = {list_q, item_reg.wpos[BLOCK_BYTES_LOG2-1:0]};
        slot_set   = 1'b0;
        slot_clr   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                taken_we = 1'b1;
                idx_next = idx_reg + BW'(1);
                if (idx_reg == BW'(NUM_BLOCKS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_link.valid && can_emit)
                begin
                    q_ready   = 1'b1;
                    item_next = q_link.item;
                    slot_next = (q_link.item.kind == K_CREATE) ? free_idx : hit_idx;
                    cnt_next  = '0;
                    idx_next  = '0;
                    run_next  = '0;
                    out_load  = 1'b1;
                    priority if (q_link.item.kind == K_CREATE)
                    begin
                        if (hit)
                            out_next.status = STAT_EXISTS;
                        else if (!free_any)
                            out_next.status = STAT_FULL;
                        else if (CW'(q_link.item.need) > CW'(free_reg))
                            out_next.status = STAT_NOSPACE;
                        else
                        begin
                            slot_set = 1'b1;
                            if (q_link.item.need != '0)
                            begin
                                out_load   = 1'b0;
                                state_next = ST_CR_RD;
                            end
                        end
                    end
                    else if (!hit)
                        out_next.status = STAT_NOTFOUND;
                    else if (q_link.item.kind == K_DELETE)
                    begin
                        if (sel_count == '0)
                            slot_clr = 1'b1;
                        else
                        begin
                            out_load   = 1'b0;
                            state_next = ST_DL_RD;
                        end
                    end
                    else if (q_link.item.end_pos > POS_W'(sel_size))
                        out_next.status = STAT_NOSPACE;
                    else if (q_link.item.kind == K_WRITE)
                    begin
                        if (q_link.item.bad_pos)
                            out_next.status = STAT_NOSPACE;
                        else
                        begin
                            out_load   = 1'b0;
                            state_next = ST_WR_MAP;
                        end
                    end
                    else if (q_link.item.too_long)
                        out_next.status = STAT_TOOLONG;
                    else if (q_link.item.amount != 21'd0)
                    begin
                        out_load   = 1'b0;
                        state_next = ST_RD_MAP;
                    end
                    else
                        // empty read: single ok beat
                        out_next.status = STAT_OK;
                end
            end
            ST_CR_RD:
            begin
                taken_re   = 1'b1;
                state_next = ST_CR_CHK;
            end
            ST_CR_CHK:
            begin
                idx_next   = idx_reg + BW'(1);
                state_next = ST_CR_RD;
                if (!taken_q)
                begin
                    taken_we  = 1'b1;
                    taken_wd  = 1'b1;
                    list_we   = 1'b1;
                    free_next = free_reg - FW'(1);
                    cnt_next  = cnt_reg + NEED_W'(1);
                    if (cnt_reg + NEED_W'(1) == item_reg.need)
                        state_next = ST_CR_DONE;
                end
            end
            ST_CR_DONE:
            begin
                if (can_emit)
                begin
                    out_load              = 1'b1;
                    out_next.blocks_given = 11'(item_reg.need);
                    state_next            = ST_IDLE;
                end
            end
            ST_DL_RD:
            begin
                list_re    = 1'b1;
                state_next = ST_DL_FREE;
            end
            ST_DL_FREE:
            begin
                taken_we   = 1'b1;
                taken_a    = list_q;
                free_next  = free_reg + FW'(1);
                cnt_next   = cnt_reg + NEED_W'(1);
                state_next = (cnt_reg + NEED_W'(1) == sel_count) ? ST_DL_DONE : ST_DL_RD;
            end
            ST_DL_DONE:
            begin
                if (can_emit)
                begin
                    slot_clr   = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WR_MAP:
            begin
                list_re    = 1'b1;
                list_ra    = list_addr(slot_reg,
                                       NEED_W'(item_reg.wpos >> BLOCK_BYTES_LOG2));
                state_next = ST_WR_STORE;
            end
            ST_WR_STORE:
            begin
                if (can_emit)
                begin
                    store_we   = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_MAP:
            begin
                list_re    = 1'b1;
                list_ra    = list_addr(slot_reg, NEED_W'(rpos >> BLOCK_BYTES_LOG2));
                state_next = ST_RD_ADDR;
            end
            ST_RD_ADDR:
            begin
                store_re   = 1'b1;
                store_a    = {list_q, rpos[BLOCK_BYTES_LOG2-1:0]};
                state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                if (can_emit)
                begin
                    out_load           = 1'b1;
                    out_next.read_byte = store_q;
                    out_next.last      = (21'(run_reg) + 21'd1 == item_reg.amount);
                    run_next           = run_reg + RUN_W'(1);
                    state_next         = out_next.last ? ST_IDLE : ST_RD_MAP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            free_reg      <= FW'(NUM_BLOCKS);
            out_valid_reg <= 1'b0;
            slot_used_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            free_reg  <= free_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (slot_set)
                slot_used_reg[slot_next] <= 1'b1;
            if (slot_clr)
                slot_used_reg[sel_slot] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        cnt_reg  <= cnt_next;
        run_reg  <= run_next;
        if (out_load)
            out_reg <= out_next;
        if (slot_set)
        begin
            slot_key_reg[slot_next]   <= q_link.item.key;
            slot_size_reg[slot_next]  <= q_link.item.amount;
            slot_count_reg[slot_next] <= q_link.item.need;
        end
    end

    // block bitmap
    always_ff @(posedge clk)
    begin
        if (taken_we)
            taken_mem[taken_a] <= taken_wd;
        if (taken_re)
            taken_q <= taken_mem[taken_a];
    end

    // per-slot block lists
    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_wa] <= list_wd;
        if (list_re)
            list_q <= list_mem[list_ra];
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_a] <= item_reg.data_byte;
        if (store_re)
            store_q <= store_mem[store_a];
    end

endmodule

`default_nettype wire

>>> src/file_table_block_allocator_unit.sv
// Byte write: the item passes the queue, a block map read and a store write before its result.
// Read: each byte takes a block list read, a store read and an output; errors answer at acceptance.
// Create: each bitmap entry scanned is read, then checked; delete: each freed block is read, then cleared.
// The front queue holds 2 items, so requests are still taken while the back end works, until it is full.
// After reset a 1-cycle-per-block pass clears the block bitmap;
// no item is executed until it ends. Slot table and output valid reset at once.
`default_nettype none

`include "assert_macros.svh"

module file_table_block_allocator_unit import ftba_pkg::*; #(
    parameter int FILE_SLOTS = FILE_SLOTS_DEF,
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ftba_req_if.sink   req,
    ftba_rsp_if.source rsp
);

    q_link_t q_link;
    logic    q_ready;

    ftba_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_link  (q_link),
        .q_ready (q_ready)
    );

    ftba_back #(
        .FILE_SLOTS (FILE_SLOTS),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_link  (q_link),
        .q_ready (q_ready),
        .rsp     (rsp)
    );

    `FTBA_ASSERT(a_pop_valid, q_ready |-> q_link.valid, "pop from empty queue")
    `FTBA_ASSERT(a_err_last, rsp.valid && rsp.item.status != STAT_OK |-> rsp.item.last, "error beat not last")
    `FTBA_ASSERT(a_err_clean, rsp.valid && rsp.item.status != STAT_OK |-> rsp.item.read_byte == 8'd0 && rsp.item.blocks_given == 11'd0, "error beat carries data")
    `FTBA_ASSERT(a_given_last, rsp.valid && rsp.item.blocks_given != 11'd0 |-> rsp.item.last && rsp.item.read_byte == 8'd0, "blocks given on non-create beat")

endmodule

`default_nettype wire
